// ----- src/tlv_pkg.sv -----
package tlv_pkg;

	localparam logic [4:0] ALGO_COUNT   = 5'd20;
	localparam logic [2:0] HDR_BYTES    = 3'd6;
	localparam logic [1:0] OUTER_FIELDS = 2'd3;
	localparam logic [1:0] INNER_FIELDS = 2'd2;

	localparam logic [1:0] KIND_OTHER  = 2'd0;
	localparam logic [1:0] KIND_DIGEST = 2'd1;
	localparam logic [1:0] KIND_PATH   = 2'd2;

	// Input beat as taken by the front end.
	typedef struct packed {
		logic        first;
		logic [31:0] total_length;
		logic [7:0]  data_byte;
	} tlv_in_t;

	// Result beat.
	typedef struct packed {
		logic [1:0] byte_kind;
		logic [7:0] value_byte;
		logic [4:0] algo_code;
		logic       done_res;
		logic       status;
	} tlv_res_t;

	function automatic logic [6:0] digest_size(input logic [4:0] algo);
		logic [6:0] s;
		begin
			case (algo)
				5'd0, 5'd1, 5'd8, 5'd14:                  s = 7'd16;
				5'd2, 5'd3, 5'd15:                        s = 7'd20;
				5'd16:                                    s = 7'd24;
				5'd7:                                     s = 7'd28;
				5'd4, 5'd9, 5'd11, 5'd17, 5'd18:          s = 7'd32;
				5'd10:                                    s = 7'd40;
				5'd5, 5'd12:                              s = 7'd48;
				5'd6, 5'd13, 5'd19:                       s = 7'd64;
				default:                                  s = 7'd0;
			endcase
			return s;
		end
	endfunction

endpackage

// ----- src/tlv_fifo.sv -----
module tlv_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tlv_pkg::tlv_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tlv_pkg::tlv_in_t out_data
);
	import tlv_pkg::*;

	// Two-entry queue between intake and the parser.
	tlv_in_t    mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> !out_valid)
		else $error("queue invented an entry");

endmodule

// ----- src/tlv_parse.sv -----
module tlv_entry_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tlv_pkg::tlv_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tlv_pkg::tlv_res_t out_data
);
	import tlv_pkg::*;

	logic [31:0] outer_left_q, inner_left_q, value_left_q;
	logic [47:0] hdr_q;
	logic [2:0]  hcnt_q;
	logic        nest_q;
	logic [1:0]  field_q;
	logic [4:0]  algo_q;
	logic [7:0]  algo_hi_q;
	logic        failed_q;
	tlv_res_t    res_q;
	logic        res_valid_q;

	logic [31:0] ol, il, vl, ol_d, il_d, vl_d, avail, rem, len;
	logic [47:0] hdr_d;
	logic [2:0]  hc, hc_d;
	logic        nest, nest_d, failed, failed_d;
	logic [1:0]  field_d, kind;
	logic [4:0]  algo_d;
	logic [7:0]  algo_hi_d, b;
	logic        have, done;
	logic [15:0] fld, code;
	logic        take;

	assign in_ready = !res_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign b        = in_data.data_byte;

	always_comb begin
		ol = outer_left_q; il = inner_left_q; vl = value_left_q;
		hdr_d = hdr_q; hc = hcnt_q; nest = nest_q; field_d = field_q;
		algo_d = algo_q; algo_hi_d = algo_hi_q; failed = failed_q;
		kind = KIND_OTHER; done = 1'b0; have = 1'b0;
		avail = '0; rem = '0; len = '0; fld = '0; code = '0;
		if (in_data.first) begin
			ol = in_data.total_length; il = '0; vl = '0; hdr_d = '0; hc = '0;
			nest = 1'b0; field_d = '0; algo_d = ALGO_COUNT; algo_hi_d = '0;
			failed = 1'b0;
			if (in_data.total_length == '0) done = 1'b1;
			else have = 1'b1;
		end else if (ol != '0) begin
			have = 1'b1;
		end
		if (have) begin
			if (failed) begin
				ol = ol - 32'd1;
			end else begin
				avail = nest ? il : ol;
				ol = ol - 32'd1;
				if (nest) il = il - 32'd1;
				if (vl != '0) begin
					vl = vl - 32'd1;
					if (nest) begin
						kind = (field_d == 2'd0) ? KIND_DIGEST : KIND_PATH;
					end else if (field_d == 2'd0) begin
						if (vl == 32'd1) begin
							algo_hi_d = b;
						end else if (vl == '0) begin
							code = {algo_hi_d, b};
							if (code >= {11'd0, ALGO_COUNT}) failed = 1'b1;
							else algo_d = code[4:0];
						end
					end
				end else if (hc == '0 && avail < {29'd0, HDR_BYTES}) begin
					failed = 1'b1;
				end else begin
					hdr_d = {hdr_d[39:0], b};
					hc = hc + 3'd1;
					if (hc >= HDR_BYTES) begin
						hc = '0;
						rem = nest ? il : ol;
						fld = hdr_d[47:32];
						len = hdr_d[31:0];
						if (fld >= {14'd0, (nest ? INNER_FIELDS : OUTER_FIELDS)}
							|| len > rem) begin
							failed = 1'b1;
						end else if (len != '0) begin
							field_d = fld[1:0];
							if (!nest && fld == 16'd0 && len != 32'd2) failed = 1'b1;
							else if (!nest && fld == 16'd1 && len != 32'd4) failed = 1'b1;
							else if (!nest && fld == 16'd2) begin
								nest = 1'b1; il = len; vl = '0; hc = '0;
							end else if (nest && fld == 16'd0 && (algo_d >= ALGO_COUNT
								|| len != {25'd0, digest_size(algo_d)})) begin
								failed = 1'b1;
							end else begin
								vl = len;
							end
						end
					end
				end
				if (!failed && nest && il == '0) nest = 1'b0;
				if (failed) kind = KIND_OTHER;
			end
			if (ol == '0) done = 1'b1;
		end
		ol_d = ol; il_d = il; vl_d = vl; hc_d = hc; nest_d = nest; failed_d = failed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_left_q <= '0; inner_left_q <= '0; value_left_q <= '0;
			hdr_q <= '0; hcnt_q <= '0; nest_q <= 1'b0; field_q <= '0;
			algo_q <= ALGO_COUNT; algo_hi_q <= '0; failed_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				outer_left_q <= ol_d; inner_left_q <= il_d; value_left_q <= vl_d;
				hdr_q <= hdr_d; hcnt_q <= hc_d; nest_q <= nest_d; field_q <= field_d;
				algo_q <= algo_d; algo_hi_q <= algo_hi_d; failed_q <= failed_d;
			end
			if (take) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.byte_kind  <= kind;
			res_q.value_byte <= (kind != KIND_OTHER) ? b : 8'd0;
			res_q.algo_code  <= algo_d;
			res_q.done_res   <= done;
			res_q.status     <= failed_d;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) hcnt_q < HDR_BYTES)
		else $error("header count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) algo_q <= ALGO_COUNT)
		else $error("algo code out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> out_data.byte_kind == KIND_OTHER)
		else $error("value byte passed after error");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

endmodule

// ----- src/tlv_digest_list_validator.sv -----
// Channel | Dir | Contents
// s_axis  | in  | tdata: total_length[31:0], data_byte[39:32]; tuser: first
// m_axis  | out | tdata: value_byte[7:0], algo_code[12:8]; tuser: byte_kind[1:0],
//         |     | status[2]; tlast: done_res
// One beat in, one beat out; a byte can be taken every cycle while the output is not stalled.
// Each beat is held in the two-entry front queue, then passes to the parser, whose header
// and length counters update combinationally and load the result register.
// Reset clears the queue, the parse state and the output valid at once.
// Either side may stall on its own; the queue and result register absorb it.
module tlv_digest_list_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // total_length[31:0], data_byte[39:32]
	input  logic        s_axis_tuser,  // first
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // value_byte[7:0], algo_code[12:8], zeros
	output logic [2:0]  m_axis_tuser,  // byte_kind[1:0], status[2]
	output logic        m_axis_tlast   // done_res
);
	import tlv_pkg::*;

	tlv_in_t  in_beat, q_beat;
	tlv_res_t res;
	logic     q_valid, q_ready;

	assign in_beat.first        = s_axis_tuser;
	assign in_beat.total_length = s_axis_tdata[31:0];
	assign in_beat.data_byte    = s_axis_tdata[39:32];

	// Front: intake queue decouples the source from the parser.
	tlv_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(in_beat),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_beat)
	);

	// Back: parser with its own result register.
	tlv_entry_parser u_parse (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_beat),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {3'd0, res.algo_code, res.value_byte};
	assign m_axis_tuser = {res.status, res.byte_kind};
	assign m_axis_tlast = res.done_res;

endmodule

// ----- tb/tb_tlv_digest_list_validator.sv -----
module tb_tlv_digest_list_validator;
	import tlv_pkg::*;

	// A local copy of the parser state predicts one result per accepted byte beat. A small
	// scoreboard queues these results and compares each output beat, field by field, with
	// the oldest one still waiting.
	// Stimulus starts with directed messages that hit the error cases and the edge values.
	// After that come random messages. Most are well formed with random content, and the
	// rest are noise or broken.

	// Scoreboard: holds the predicted results and checks the observed ones.
	class tlv_scoreboard;
		tlv_res_t pending[$];
		int errors;

		function void note_input(tlv_res_t r);
			pending.push_back(r);
		endfunction

		function void check_result(tlv_res_t got);
			tlv_res_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			exp_r = pending.pop_front();
			// Every field is compared on its own.
			if (got.byte_kind !== exp_r.byte_kind || got.value_byte !== exp_r.value_byte ||
			    got.algo_code !== exp_r.algo_code || got.done_res !== exp_r.done_res ||
			    got.status !== exp_r.status) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp kind=%0d val=%h algo=%0d done=%0d st=%0d,",
						" got kind=%0d val=%h algo=%0d done=%0d st=%0d"},
						exp_r.byte_kind, exp_r.value_byte, exp_r.algo_code, exp_r.done_res,
						exp_r.status, got.byte_kind, got.value_byte, got.algo_code,
						got.done_res, got.status);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	tlv_digest_list_validator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	tlv_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles = 0;

	// The predictor keeps its own copy of the parser state.
	logic [31:0] msg_left;
	logic [31:0] entry_left;
	logic [31:0] val_left;
	logic [47:0] hdr_shift;
	logic [2:0]  hdr_cnt;
	logic        in_entry;
	logic [1:0]  fld;
	logic [4:0]  algo;
	logic [7:0]  algo_hi;
	logic        bad;

	// Message bytes that are waiting to be sent.
	logic [7:0] msg[$];

	function automatic logic [6:0] size_of_algo(input logic [4:0] a);
		logic [6:0] s;
		case (a)
			0, 1, 8, 14:         s = 7'd16;
			2, 3, 15:            s = 7'd20;
			16:                  s = 7'd24;
			7:                   s = 7'd28;
			4, 9, 11, 17, 18:    s = 7'd32;
			10:                  s = 7'd40;
			5, 12:               s = 7'd48;
			default:             s = 7'd64;
		endcase
		return s;
	endfunction

	function automatic void clear_parse();
		msg_left = 0; entry_left = 0; val_left = 0; hdr_shift = 0; hdr_cnt = 0;
		in_entry = 0; fld = 0; algo = ALGO_COUNT; algo_hi = 0; bad = 0;
	endfunction

	// Runs the check at the end of a header: field range, length bounds and the field rules.
	function automatic void finish_header(input logic [31:0] room);
		logic [15:0] f;
		logic [31:0] len;
		f = hdr_shift[47:32];
		len = hdr_shift[31:0];
		if (f >= (in_entry ? INNER_FIELDS : OUTER_FIELDS) || len > room) begin
			bad = 1;
			return;
		end
		if (len == 0)
			return;
		fld = f[1:0];
		if (!in_entry) begin
			if ((f == 0 && len != 2) || (f == 1 && len != 4)) begin
				bad = 1;
				return;
			end
			if (f == 2) begin
				in_entry = 1; entry_left = len; val_left = 0; hdr_cnt = 0;
				return;
			end
		end else if (f == 0) begin
			if (algo >= ALGO_COUNT || len != {25'd0, size_of_algo(algo)}) begin
				bad = 1;
				return;
			end
		end
		val_left = len;
	endfunction

	// Works out the result of one accepted beat and updates the predicted state.
	function automatic tlv_res_t predict_beat(input logic first, input logic [31:0] total,
		input logic [7:0] b);
		tlv_res_t r;
		logic [1:0] kind;
		logic [31:0] avail;
		logic [15:0] code;
		logic take;
		logic done;
		kind = KIND_OTHER; take = 0; done = 0;
		if (first) begin
			clear_parse();
			msg_left = total;
			if (total == 0)
				done = 1;
			else
				take = 1;
		end else if (msg_left != 0) begin
			take = 1;
		end
		if (take) begin
			if (bad) begin
				msg_left--;
			end else begin
				avail = in_entry ? entry_left : msg_left;
				msg_left--;
				if (in_entry)
					entry_left--;
				if (val_left > 0) begin
					val_left--;
					if (in_entry) begin
						kind = (fld == 0) ? KIND_DIGEST : KIND_PATH;
					end else if (fld == 0) begin
						if (val_left == 1) begin
							algo_hi = b;
						end else if (val_left == 0) begin
							code = {algo_hi, b};
							if (code >= ALGO_COUNT)
								bad = 1;
							else
								algo = code[4:0];
						end
					end
				end else if (hdr_cnt == 0 && avail < HDR_BYTES) begin
					// A header that cannot fit in the bytes left fails at its first byte.
					bad = 1;
				end else begin
					hdr_shift = {hdr_shift[39:0], b};
					hdr_cnt++;
					if (hdr_cnt >= HDR_BYTES) begin
						hdr_cnt = 0;
						finish_header(in_entry ? entry_left : msg_left);
					end
				end
				if (!bad && in_entry && entry_left == 0)
					in_entry = 0;
				if (bad)
					kind = KIND_OTHER;
			end
			if (msg_left == 0)
				done = 1;
		end
		r.byte_kind = kind;
		r.value_byte = (kind != KIND_OTHER) ? b : 8'd0;
		r.algo_code = algo;
		r.done_res = done;
		r.status = bad;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// This block keeps the cycle count and ends the run at the watchdog limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// This block samples the output side and stalls the receiver at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result({m_axis_tuser[1:0], m_axis_tdata[7:0], m_axis_tdata[12:8],
					m_axis_tlast, m_axis_tuser[2]});
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sends one beat and waits for its handshake. Random idle gaps come before the beat.
	// The valid stays high after the handshake until the next beat or an idle gap.
	task automatic send_beat(input logic first, input logic [31:0] total,
		input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= first;
		s_axis_tdata <= {b, total};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(predict_beat(first, total, b));
	endtask

	// Sends the queued bytes as one message. A length adjustment can break the message.
	task automatic send_msg(input int len_adj);
		logic [31:0] tot;
		tot = 32'(msg.size() + len_adj);
		for (int i = 0; i < msg.size(); i++)
			send_beat(i == 0, tot, msg[i]);
		msg.delete();
	endtask

	task automatic put_hdr(input logic [15:0] f, input logic [31:0] len);
		msg.push_back(f[15:8]); msg.push_back(f[7:0]);
		for (int i = 3; i >= 0; i--)
			msg.push_back(len[i*8 +: 8]);
	endtask

	task automatic put_rand(input int n);
		repeat (n) msg.push_back(8'($urandom_range(255)));
	endtask

	// Queues a message with random content, well formed when fault is zero; else fault picks a fault.
	task automatic build_msg(input int fault);
		logic [4:0] a;
		int n_ent;
		int body;
		int dl;
		int pl;
		a = 5'($urandom_range(19));
		if (fault != 3) begin
			put_hdr(16'd0, 32'd2); msg.push_back(8'd0);
			msg.push_back(fault == 1 ? 8'(20 + $urandom_range(235)) : {3'd0, a});
		end
		put_hdr(16'd1, 32'd4); put_rand(4);
		n_ent = $urandom_range(1, 3);
		repeat (n_ent) begin
			dl = size_of_algo(a);
			if (fault == 2)
				dl = dl + 1;
			pl = $urandom_range(0, 6);
			body = 6 + dl + 6 + pl;
			put_hdr(16'd2, 32'(body));
			put_hdr(16'd0, 32'(dl)); put_rand(dl);
			put_hdr(16'd1, 32'(pl)); put_rand(pl);
		end
		if (fault == 4)
			put_hdr(16'($urandom_range(3, 65535)), 32'd0);
		if (fault == 5)
			put_hdr(16'd0, 32'd0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int mode;
		sb = new();
		send_idle_pct = 17;
		recv_idle_pct = 56;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		clear_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part.
		// An empty message, then a byte with no message open.
		send_beat(1, 0, 8'hFF);
		send_beat(0, 32'hFFFF_FFFF, 8'hAA);
		build_msg(0); send_msg(0);
		// An algo value out of range, a digest length that is wrong, and a digest with no algo field.
		build_msg(1); send_msg(0);
		build_msg(2); send_msg(0);
		build_msg(3); send_msg(0);
		// A bad outer field.
		put_hdr(16'hFFFF, 32'hFFFF_FFFF); send_msg(0);
		put_hdr(16'd3, 32'd0); send_msg(0);
		// A short header.
		put_rand(3); send_msg(0);
		// A length that runs past the message, and a count with the wrong length.
		put_hdr(16'd1, 32'd9); put_rand(2); send_msg(0);
		put_hdr(16'd1, 32'd3); put_rand(3); send_msg(0);
		// A zero-length value, and an algo whose length is not 2.
		put_hdr(16'd0, 32'd0); put_hdr(16'd1, 32'd0); put_hdr(16'd2, 32'd0); send_msg(0);
		put_hdr(16'd0, 32'd3); put_rand(3); send_msg(0);
		// A bad inner field, and a message with bytes beyond its total length.
		put_hdr(16'd2, 32'd6); put_hdr(16'd2, 32'd0); send_msg(0);
		put_hdr(16'd1, 32'd4); put_rand(4); send_msg(-2);
		send_beat(0, 0, 8'h55);
		drain();

		// Random part, in three idle phases.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 56 : 0;
			recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 17 : 0;
			for (int k = 0; k < 3; k++) begin
				mode = $urandom_range(15);
				if (mode < 10) begin
					build_msg(0); send_msg(0);
				end else if (mode < 14) begin
					build_msg($urandom_range(1, 5)); send_msg($urandom_range(0, 3) - 1);
				end else begin
					put_rand($urandom_range(1, 30)); send_msg($urandom_range(0, 2));
				end
				if (mode == 15)
					send_beat(0, $urandom, 8'($urandom_range(255)));
			end
			drain();
		end

		// All stimulus has been sent. Wait for the outstanding results to arrive.
		drain();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- tlv_digest_list_validator.f -----
src/tlv_pkg.sv
src/tlv_fifo.sv
src/tlv_parse.sv
src/tlv_digest_list_validator.sv
tb/tb_tlv_digest_list_validator.sv
